/* sv/timer_slot_pool_top_macros.svh */
// ----------------------------------------------------------------------------
// Timer slot pool assertion macros
// Shorthands for the concurrent assertions of the slot pool checker.
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_POOL_TOP_MACROS_SVH
`define TIMER_SLOT_POOL_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define TSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// Timer slot pool package
// Shared widths, constants and operation codes.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int TICK_W   = 16;
    localparam int HANDLE_W = 8;
    localparam int MODE_W   = 3;
    localparam int PROD_W   = 26;
    localparam int SLOT_W   = 2 * TICK_W;

    localparam logic [9:0]          MS_TO_US            = 10'd1000;
    localparam logic [HANDLE_W-1:0] HANDLE_BASE         = 8'h10;
    localparam logic [TICK_W-1:0]   DEFAULT_INTERVAL_US = 16'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_CLEAR   = 3'd1,
        MODE_ALLOC   = 3'd2,
        MODE_QUERY   = 3'd3,
        MODE_RELEASE = 3'd4,
        MODE_RESTART = 3'd5
    } mode_t;

endpackage

/* sv/tsp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address for read and write, registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tsp_div.sv */
// ----------------------------------------------------------------------------
// Timer slot pool divider
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module tsp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsp_pkg::PROD_W-1:0] dividend,
    input  logic [tsp_pkg::TICK_W-1:0] divisor,
    output logic                       done,
    output logic [tsp_pkg::TICK_W-1:0] quotient
);
    import tsp_pkg::*;

    localparam int CW = $clog2(PROD_W + 1);

    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] rem_next;
    logic [PROD_W-1:0] quo_reg;
    logic [TICK_W-1:0] divisor_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TICK_W:0]   shifted;
    logic [TICK_W+1:0] diff;
    logic              fits;

    assign shifted  = {rem_reg, quo_reg[PROD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, divisor_reg};
    assign fits     = !diff[TICK_W+1];
    assign rem_next = fits ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
            cnt_reg     <= CW'(PROD_W);
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[TICK_W-1:0];

endmodule

/* sv/timer_slot_pool_top.sv */
// ----------------------------------------------------------------------------
// Timer slot pool
// A pool of timer slots on a wrapping 16-bit tick counter, with allocate,
// query, release and restart operations and a millisecond-to-tick divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  s_        in         s_valid s_ready s_mode s_time_ms s_handle
//  m_        out        m_valid m_ready m_ok m_handle_out m_tick_now
//  cfg_      in         cfg_valid cfg_ready cfg_tick_interval_us
//
//  One item is worked on at a time. Tick, clear, release and unused modes pass
//  through decode to the result state; query and restart with a matching handle
//  add one RAM read. Allocate waits for both the 26-step divider and the
//  free-slot scan to finish. Reset frees every slot at once; no clearing pass is
//  needed. A result waits in the output register while a new item is accepted;
//  that item finishes once the register is free again.
// ----------------------------------------------------------------------------
module timer_slot_pool_top #(
    parameter int SLOTS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tsp_pkg::MODE_W-1:0]   s_mode,
    input  logic [tsp_pkg::TICK_W-1:0]   s_time_ms,
    input  logic [tsp_pkg::HANDLE_W-1:0] s_handle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [tsp_pkg::HANDLE_W-1:0] m_handle_out,
    output logic [tsp_pkg::TICK_W-1:0]   m_tick_now,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tsp_pkg::TICK_W-1:0]   cfg_tick_interval_us
);
    import tsp_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_START,
        ST_DIV,
        ST_RMW,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [TICK_W-1:0]   ms_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   interval_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [IW-1:0]       scan_idx_reg;
    logic                scan_fin_reg;
    logic                scan_hit_reg;
    logic                res_ok_reg;
    logic [HANDLE_W-1:0] res_hout_reg;
    logic                m_valid_reg;
    logic                m_ok_reg;
    logic [HANDLE_W-1:0] m_hout_reg;
    logic [TICK_W-1:0]   m_tick_reg;

    logic [HANDLE_W-1:0] hoff;
    logic [IW-1:0]       hidx;
    logic                hmatch;
    logic                div_start;
    logic                div_done;
    logic [TICK_W-1:0]   div_quot;
    logic                alloc_end;
    logic                ram_we;
    logic [IW-1:0]       ram_addr;
    logic [SLOT_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]   ram_rdata;

    // Handles map straight onto slot indices, so a lookup needs no search.
    assign hoff   = handle_reg - HANDLE_BASE;
    assign hidx   = hoff[IW-1:0];
    assign hmatch = (handle_reg >= HANDLE_BASE) && (hoff < HANDLE_W'(SLOTS)) &&
                    valid_reg[hidx];

    assign div_start = (state_reg == ST_START);
    assign alloc_end = (state_reg == ST_DIV) && div_done && scan_fin_reg;

    tsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (interval_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Each RAM word holds the period in the upper half, the deadline below.
    always_comb begin
        ram_we = (alloc_end && scan_hit_reg) ||
                 ((state_reg == ST_RMW) && (mode_reg == MODE_RESTART));
        if (state_reg == ST_DIV) begin
            ram_addr  = scan_idx_reg;
            ram_wdata = {div_quot, div_quot + tick_reg};
        end else begin
            ram_addr  = hidx;
            ram_wdata = {ram_rdata[SLOT_W-1:TICK_W], ram_rdata[SLOT_W-1:TICK_W] + tick_reg};
        end
    end

    tsp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            interval_reg <= DEFAULT_INTERVAL_US;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                interval_reg <= cfg_tick_interval_us;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        ms_reg     <= s_time_ms;
                        handle_reg <= s_handle;
                        state_reg  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    res_ok_reg   <= 1'b0;
                    res_hout_reg <= '0;
                    prod_reg     <= PROD_W'(ms_reg) * PROD_W'(MS_TO_US);
                    scan_idx_reg <= '0;
                    scan_fin_reg <= 1'b0;
                    scan_hit_reg <= 1'b0;
                    state_reg    <= ST_DONE;
                    unique case (mode_reg)
                        MODE_TICK: begin
                            tick_reg <= tick_reg + 1'b1;
                        end
                        MODE_CLEAR: begin
                            valid_reg <= '0;
                        end
                        MODE_ALLOC: begin
                            state_reg <= ST_START;
                        end
                        MODE_QUERY, MODE_RESTART: begin
                            if (hmatch) begin
                                state_reg <= ST_RMW;
                            end
                        end
                        MODE_RELEASE: begin
                            if (hmatch) begin
                                valid_reg[hidx] <= 1'b0;
                                res_ok_reg      <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_START, ST_DIV: begin
                    if (!scan_fin_reg) begin
                        if (!valid_reg[scan_idx_reg]) begin
                            scan_fin_reg <= 1'b1;
                            scan_hit_reg <= 1'b1;
                        end else if (scan_idx_reg == IW'(SLOTS - 1)) begin
                            scan_fin_reg <= 1'b1;
                        end else begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    if (state_reg == ST_START) begin
                        state_reg <= ST_DIV;
                    end else if (alloc_end) begin
                        if (scan_hit_reg) begin
                            valid_reg[scan_idx_reg] <= 1'b1;
                            res_ok_reg              <= 1'b1;
                            res_hout_reg            <= HANDLE_BASE + HANDLE_W'(scan_idx_reg);
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_RMW: begin
                    if (mode_reg == MODE_QUERY) begin
                        res_ok_reg <= (ram_rdata[TICK_W-1:0] < tick_reg);
                    end else begin
                        res_ok_reg <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_ok_reg    <= res_ok_reg;
                        m_hout_reg  <= res_hout_reg;
                        m_tick_reg  <= tick_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_handle_out = m_hout_reg;
    assign m_tick_now   = m_tick_reg;

endmodule

/* sv/tsp_checker.sv */
// ----------------------------------------------------------------------------
// Timer slot pool checker
// Port-level assertions on the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "timer_slot_pool_top_macros.svh"

module tsp_checker #(
    parameter int SLOTS = 8
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_ok,
    input logic [tsp_pkg::HANDLE_W-1:0] m_handle_out,
    input logic [tsp_pkg::TICK_W-1:0]   m_tick_now
);
    import tsp_pkg::*;

    `TSP_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_handle_out) && $stable(m_tick_now), "Stalled result item changed")
    `TSP_ASSERT(a_handle_granted, m_valid && (m_handle_out != '0) |-> m_ok && (m_handle_out >= HANDLE_BASE) && (m_handle_out < HANDLE_BASE + HANDLE_W'(SLOTS)), "Handle out of range or without grant")
    `TSP_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "Second item accepted while one is in progress")
    `TSP_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "Result valid after reset")

endmodule

bind timer_slot_pool_top tsp_checker #(.SLOTS(SLOTS)) u_tsp_checker (.*);
